/* rtl/srp256_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp256_pkg
// Shared constants, types and cipher functions for the Serpent-256 core.
// ----------------------------------------------------------------------------
package srp256_pkg;

	localparam int RK_ENTRIES = 33;               // one 128-bit round key per entry
	localparam int RK_AW      = $clog2(RK_ENTRIES);
	localparam int PK_WORDS   = 132;
	localparam int PK_CW      = $clog2(PK_WORDS);
	localparam logic [RK_AW-1:0] LAST_STEP = RK_AW'(RK_ENTRIES - 1);
	localparam logic [31:0] GOLDEN = 32'h9E37_79B9;

	// configuration register indexes
	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;

	// round key write request from the key schedule
	typedef struct packed {
		logic             we;
		logic [RK_AW-1:0] addr;
		logic [127:0]     data;
	} srp256_kwr_t;

	// S-box tables, nibble x at bits [4x+3:4x]
	function automatic logic [63:0] sbox_tab(input logic [2:0] box, input logic inv);
		logic [63:0] t;
		t = '0;
		if (!inv) begin
			case (box)
				3'd0: t = 64'hC907_24DE_B56A_1F83;
				3'd1: t = 64'h43D6_8EB1_A509_72CF;
				3'd2: t = 64'h25B0_4E1D_FAC3_9768;
				3'd3: t = 64'hE57A_421D_369C_8BF0;
				3'd4: t = 64'hD7E9_A452_6B0C_38F1;
				3'd5: t = 64'h176D_8E30_C9A4_B25F;
				3'd6: t = 64'h0A3D_F19E_B648_5C27;
				3'd7: t = 64'h6539_AC47_B28E_0FD1;
				default: t = '0;
			endcase
		end else begin
			case (box)
				3'd0: t = 64'h289F_74E1_C56A_0B3D;
				3'd1: t = 64'h0AD1_974B_3C6F_E285;
				3'd2: t = 64'h7A85_D630_21EB_4F9C;
				3'd3: t = 64'h1F84_2C53_D6EB_7A90;
				3'd4: t = 64'h1DF4_6BC2_E79A_3805;
				3'd5: t = 64'h0AC7_356B_ED14_92F8;
				3'd6: t = 64'hB8C2_7E94_0635_D1AF;
				3'd7: t = 64'h241A_7BC5_8FE9_D603;
				default: t = '0;
			endcase
		end
		return t;
	endfunction

	// bitsliced S-box over words {w3,w2,w1,w0}
	function automatic logic [127:0] sbox128(input logic [127:0] b, input logic [2:0] box,
			input logic inv);
		logic [63:0]  t;
		logic [3:0]   v;
		logic [3:0]   o;
		logic [127:0] r;
		t = sbox_tab(box, inv);
		r = '0;
		for (int j = 0; j < 32; j++) begin
			v = {b[96+j], b[64+j], b[32+j], b[j]};
			o = t[{v, 2'b00} +: 4];
			r[j]    = o[0];
			r[32+j] = o[1];
			r[64+j] = o[2];
			r[96+j] = o[3];
		end
		return r;
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [127:0] lin_fwd(input logic [127:0] b);
		logic [31:0] b0, b1, b2, b3;
		b0 = b[31:0]; b1 = b[63:32]; b2 = b[95:64]; b3 = b[127:96];
		b0 = rotl(b0, 13);
		b2 = rotl(b2, 3);
		b1 = b1 ^ b0 ^ b2;
		b3 = b3 ^ b2 ^ (b0 << 3);
		b1 = rotl(b1, 1);
		b3 = rotl(b3, 7);
		b0 = b0 ^ b1 ^ b3;
		b2 = b2 ^ b3 ^ (b1 << 7);
		b0 = rotl(b0, 5);
		b2 = rotl(b2, 22);
		return {b3, b2, b1, b0};
	endfunction

	function automatic logic [127:0] lin_inv(input logic [127:0] b);
		logic [31:0] b0, b1, b2, b3;
		b0 = b[31:0]; b1 = b[63:32]; b2 = b[95:64]; b3 = b[127:96];
		b2 = rotl(b2, 10);
		b0 = rotl(b0, 27);
		b2 = b2 ^ b3 ^ (b1 << 7);
		b0 = b0 ^ b1 ^ b3;
		b3 = rotl(b3, 25);
		b1 = rotl(b1, 31);
		b3 = b3 ^ b2 ^ (b0 << 3);
		b1 = b1 ^ b0 ^ b2;
		b2 = rotl(b2, 29);
		b0 = rotl(b0, 19);
		return {b3, b2, b1, b0};
	endfunction

endpackage
`default_nettype wire

/* rtl/srp256_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp256_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srp256_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/srp256_keyexp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp256_keyexp
// Key schedule: one prekey word per cycle from an 8-word sliding window;
// every fourth word closes a group that goes through its S-box into the store.
// ----------------------------------------------------------------------------
module srp256_keyexp import srp256_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [255:0]  key,
	output srp256_kwr_t        wr,
	output logic               done
);
	logic [31:0]      win_q [8];
	logic [PK_CW-1:0] cnt_q;
	logic             active_q;
	logic [31:0]      p;
	logic [31:0]      x;
	logic [2:0]       box;

	assign x   = win_q[0] ^ win_q[3] ^ win_q[5] ^ win_q[7] ^ GOLDEN ^ 32'(cnt_q);
	assign p   = rotl(x, 11);
	// group g uses S-box (3 - g) mod 8
	assign box = 3'd3 - cnt_q[4:2];

	assign wr.we   = active_q && (cnt_q[1:0] == 2'd3);
	assign wr.addr = cnt_q[PK_CW-1:2];
	assign wr.data = sbox128({p, win_q[7], win_q[6], win_q[5]}, box, 1'b0);
	assign done    = active_q && (cnt_q == PK_CW'(PK_WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (start) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (active_q) begin
			active_q <= !done;
			cnt_q    <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < 8; k++) begin
				win_q[k] <= key[32*k +: 32];
			end
		end else if (active_q) begin
			for (int k = 0; k < 7; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[7] <= p;
		end
	end
endmodule
`default_nettype wire

/* rtl/srp256_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp256_round
// One cipher step: key mix, S-box and linear transform, either direction.
// ----------------------------------------------------------------------------
module srp256_round import srp256_pkg::*; (
	input  wire logic [127:0]     blk,
	input  wire logic [127:0]     rkey,
	input  wire logic             dec,
	input  wire logic [RK_AW-1:0] step,
	output logic      [127:0]     nxt
);
	logic [127:0]     mixed;
	logic [127:0]     t;
	logic [127:0]     pre;
	logic [RK_AW-1:0] ridx;

	assign mixed = blk ^ rkey;
	assign ridx  = LAST_STEP - step;
	assign t     = sbox128(mixed, step[2:0], 1'b0);
	// decrypt: the step right after the final key mix skips the inverse transform
	assign pre   = (step == RK_AW'(1)) ? blk : lin_inv(blk);

	always_comb begin
		if (!dec) begin
			if (step == LAST_STEP) begin
				nxt = mixed;
			end else if (step == LAST_STEP - 1'b1) begin
				nxt = t;
			end else begin
				nxt = lin_fwd(t);
			end
		end else begin
			if (step == '0) begin
				nxt = mixed;
			end else begin
				nxt = sbox128(pre, ridx[2:0], 1'b1) ^ rkey;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/serpent256_block_cipher_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// serpent256_block_cipher_core
// Serpent-256 encrypt/decrypt, round keys held in a 33 x 128 RAM.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  in       in_valid/in_stall, action, block_*   request in
//  out      out_valid/out_stall, out_lo/out_hi   request out
//  cfg      cfg_we, cfg_index, cfg_data          key register writes
//
//  A block runs from accept to result through one key RAM read prime,
//  33 steps (32 rounds plus final key mix, one round key read per step)
//  and a load of the output register.
//  After a key write the next block first runs the schedule: 132 prekey
//  words, one prekey word per cycle. Reset leaves the schedule invalid.
//  in_stall is high while a block is in work; a stalled result holds.
// ----------------------------------------------------------------------------
module serpent256_block_cipher_core import srp256_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        action,
	input  wire logic [63:0] block_lo,
	input  wire logic [63:0] block_hi,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] out_lo,
	output logic      [63:0] out_hi,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_PRIME  = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]       state_q;
	logic [63:0]      key_q [4];
	logic             ready_q;
	logic [127:0]     data_q;
	logic             dec_q;
	logic [RK_AW-1:0] step_q;
	logic             out_valid_q;
	logic [127:0]     out_q;

	logic             accept;
	logic             kx_done;
	srp256_kwr_t      kwr;
	logic [RK_AW-1:0] rd_step;
	logic [RK_AW-1:0] raddr;
	logic [127:0]     rkey;
	logic [127:0]     nxt;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_lo    = out_q[63:0];
	assign out_hi    = out_q[127:64];

	// read one step ahead of the datapath
	always_comb begin
		if (state_q == ST_RUN && step_q != LAST_STEP) begin
			rd_step = step_q + 1'b1;
		end else if (state_q == ST_RUN) begin
			rd_step = step_q;
		end else begin
			rd_step = '0;
		end
		raddr = dec_q ? (LAST_STEP - rd_step) : rd_step;
	end

	srp256_keyexp u_keyexp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && !ready_q),
		.key    ({key_q[3], key_q[2], key_q[1], key_q[0]}),
		.wr     (kwr),
		.done   (kx_done)
	);

	srp256_ram #(.W(128), .D(RK_ENTRIES)) u_rk_ram (
		.clk   (clk),
		.we    (kwr.we),
		.waddr (kwr.addr),
		.wdata (kwr.data),
		.raddr (raddr),
		.rdata (rkey)
	);

	srp256_round u_round (
		.blk  (data_q),
		.rkey (rkey),
		.dec  (dec_q),
		.step (step_q),
		.nxt  (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ready_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				key_q[k] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY0: key_q[0] <= cfg_data;
					REG_KEY1: key_q[1] <= cfg_data;
					REG_KEY2: key_q[2] <= cfg_data;
					REG_KEY3: key_q[3] <= cfg_data;
					default: ;
				endcase
				ready_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q  <= '0;
						state_q <= ready_q ? ST_PRIME : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (kx_done) begin
						ready_q <= 1'b1;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= {block_hi, block_lo};
			dec_q  <= action;
		end else if (state_q == ST_RUN) begin
			data_q <= nxt;
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_q <= data_q;
		end
	end
endmodule
`default_nettype wire

/* rtl/srp256_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srp256_checker
// Port-level checks on the Serpent-256 core, bound to the top level.
// ----------------------------------------------------------------------------
module srp256_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] out_lo,
	input wire logic [63:0] out_hi
);
	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_lo) && $stable(out_hi))
		else $error("stalled result changed");

	// one block at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	// no result can appear right after a request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");
endmodule

bind serpent256_block_cipher_core srp256_checker u_srp256_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_lo    (out_lo),
	.out_hi    (out_hi)
);
`default_nettype wire
